### hdl/lsr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lsr_pkg
// Shared constants for the LIFO stack with reverse: field widths, defaults,
// operation codes and status codes.
// ============================================================================
package lsr_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int FIELD_W  = 32;
    localparam int CAP_W    = 9;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] REG_CAPACITY = 2'd0;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

### hdl/lifo_stack_with_reverse.sv
`timescale 1ns / 1ps
// ============================================================================
// lifo_stack_with_reverse
// Bounded LIFO stack of signed words in a RAM. Operations: push, pop, peek,
// reverse (pairwise swaps from both ends) and query. One result per
// transaction with value, status, count and full/empty flags.
// ============================================================================
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  input    | in_valid / in_stall        | mode, push_value
//  output   | out_valid / out_stall      | read_value, status, item_count,
//           |                            | is_full, is_empty
//  config   | psel penable pwrite pready | paddr, pwdata, prdata
//
//  Push, pop, peek and query: accept, then result register load.
//  Reverse: floor(n/2) swaps for n entries; each swap is two reads
//  and two writes through the single-read, single-write RAM port pair.
//  in_stall is high from accept until the result is loaded into the output
//  register; a new transaction is taken while that result waits.
//  Reset empties the stack and sets cap_reg to 256; RAM is not cleared.
//
module lifo_stack_with_reverse #(
    parameter int DEPTH      = lsr_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = lsr_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lsr_pkg::MODE_W-1:0]          mode,
    input  logic signed [lsr_pkg::FIELD_W-1:0]  push_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lsr_pkg::FIELD_W-1:0]  read_value,
    output logic [lsr_pkg::STATUS_W-1:0]        status,
    output logic [lsr_pkg::COUNT_W-1:0]         item_count,
    output logic                                is_full,
    output logic                                is_empty,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lsr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lsr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lsr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    import lsr_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DONE      = 6'b000010,
        S_REV_RD_LO = 6'b000100,
        S_REV_RD_HI = 6'b001000,
        S_REV_WR_LO = 6'b010000,
        S_REV_WR_HI = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CAP_W-1:0]        cap_reg;
    logic [ADDR_W-1:0]       lo_reg, lo_next;
    logic [ADDR_W-1:0]       hi_reg, hi_next;
    logic [DATA_WIDTH-1:0]   tmp_reg, tmp_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic                    rd_src_reg, rd_src_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [FIELD_W-1:0] read_value_reg;
    logic [STATUS_W-1:0]     status_out_reg;
    logic [COUNT_W-1:0]      item_count_reg;
    logic                    is_full_reg;
    logic                    is_empty_reg;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [DATA_WIDTH-1:0]   ram_wdata;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [DATA_WIDTH-1:0]   ram_rdata;

    logic [CMP_W-1:0]        eff_cap;
    logic                    full_now;
    logic [CNT_W-1:0]        count_m1;
    logic [ADDR_W-1:0]       lo_inc;
    logic [ADDR_W-1:0]       hi_dec;
    logic                    out_load;
    logic                    cfg_write;

    lsr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // capacity clamped to 1..DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(DEPTH))
        begin
            eff_cap = CMP_W'(DEPTH);
        end
        else
        begin
            eff_cap = CMP_W'(cap_reg);
        end
    end

    assign full_now = CMP_W'(count_reg) >= eff_cap;
    assign count_m1 = count_reg - CNT_W'(1);
    assign lo_inc   = lo_reg + ADDR_W'(1);
    assign hi_dec   = hi_reg - ADDR_W'(1);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        tmp_next    = tmp_reg;
        status_next = status_reg;
        rd_src_next = rd_src_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = ST_OK;
                    rd_src_next = 1'b0;
                    state_next  = S_DONE;
                    case (mode) inside
                        MODE_PUSH:
                        begin
                            if (full_now)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[ADDR_W-1:0];
                                ram_wdata  = DATA_WIDTH'($unsigned(push_value));
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_POP, MODE_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                ram_raddr   = count_m1[ADDR_W-1:0];
                                rd_src_next = 1'b1;
                                if (mode == MODE_POP)
                                begin
                                    count_next = count_m1;
                                end
                            end
                        end
                        MODE_REVERSE:
                        begin
                            if (count_reg > CNT_W'(1))
                            begin
                                lo_next    = '0;
                                hi_next    = count_m1[ADDR_W-1:0];
                                state_next = S_REV_RD_LO;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_REV_RD_LO:
            begin
                ram_re     = 1'b1;
                ram_raddr  = lo_reg;
                state_next = S_REV_RD_HI;
            end
            S_REV_RD_HI:
            begin
                ram_re     = 1'b1;
                ram_raddr  = hi_reg;
                tmp_next   = ram_rdata;
                state_next = S_REV_WR_LO;
            end
            S_REV_WR_LO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = ram_rdata;
                state_next = S_REV_WR_HI;
            end
            S_REV_WR_HI:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = tmp_reg;
                lo_next   = lo_inc;
                hi_next   = hi_dec;
                if (lo_inc < hi_dec)
                begin
                    state_next = S_REV_RD_LO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    assign cfg_write = psel && penable && pwrite && (paddr == REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        tmp_reg     <= tmp_next;
        status_reg  <= status_next;
        rd_src_reg  <= rd_src_next;
        if (out_load)
        begin
            read_value_reg <= rd_src_reg ? FIELD_W'(ram_rdata) : '0;
            status_out_reg <= status_reg;
            item_count_reg <= COUNT_W'(count_reg);
            is_full_reg    <= full_now;
            is_empty_reg   <= (count_reg == '0);
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_out_reg;
    assign item_count = item_count_reg;
    assign is_full    = is_full_reg;
    assign is_empty   = is_empty_reg;
    assign prdata     = APB_DATA_W'(cap_reg);
    assign pready     = 1'b1;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("count exceeds depth");

    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode == MODE_PUSH && !full_now)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not advance count");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OVERFLOW) |-> is_full)
        else $error("overflow without full");

    a_udf_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_UNDERFLOW) |-> (is_empty && read_value == '0))
        else $error("underflow with data");

    a_rev_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REV_RD_LO) |-> (lo_reg < hi_reg))
        else $error("reverse pointers crossed");

endmodule

### hdl/lsr_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// lsr_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ============================================================================
module lsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
